[design/rrp_pkg.sv]
// Shared types, constants and fixed-point helpers of the rounded rectangle path generator.
// No dependencies; every other design file imports this package.
package rrp_pkg;

  typedef logic signed [23:0] val_t;

  localparam val_t VMAX = 24'sh7FFFFF;
  localparam val_t VMIN = 24'sh800000;

  localparam int SQRT_STAGES = 12;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_ARC   = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef struct packed {
    val_t x;
    val_t y;
    val_t xw;
    val_t yh;
    val_t hw;
    val_t hh;
    logic drawable;
  } geo_t;

  // Item travelling alongside the square root
  typedef struct packed {
    geo_t             geo;
    logic             full;
    logic [3:0][51:0] corner;
  } sq_item_t;

  typedef struct packed {
    geo_t            geo;
    logic            rounded;
    logic [3:0][23:0] rx;
    logic [3:0][23:0] ry;
  } path_t;

  function automatic val_t sat_wide(input logic signed [48:0] v);
    val_t r;
    if (v > 49'(VMAX)) r = VMAX;
    else if (v < 49'(VMIN)) r = VMIN;
    else r = v[23:0];
    return r;
  endfunction

  function automatic val_t sadd(input val_t a, input val_t b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    return sat_wide(s);
  endfunction

  function automatic val_t ssub(input val_t a, input val_t b);
    logic signed [48:0] s;
    s = 49'(a) - 49'(b);
    return sat_wide(s);
  endfunction

  // Round half up and saturate a product with frac fractional bits too many
  function automatic val_t mulq(input logic signed [47:0] prod, input int frac);
    logic signed [48:0] t;
    t = 49'(prod) + (49'sd1 <<< (frac - 1));
    t = t >>> frac;
    return sat_wide(t);
  endfunction

  function automatic logic [22:0] radius_mag(input val_t r);
    logic signed [24:0] m;
    logic [22:0]        res;
    m = (r < 0) ? -25'(r) : 25'(r);
    if (m > 25'(VMAX)) res = 23'h7FFFFF;
    else res = m[22:0];
    return res;
  endfunction

endpackage

[design/rrp_resolve.sv]
// Front stages: scale the six rectangle values, resolve x, y, width and height,
// and form half the sum of the squared width and height. Depends on rrp_pkg.
module rrp_resolve import rrp_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  val_t [5:0]       in_val,
  input  logic [11:0]      in_flags,
  input  logic             in_full,
  input  logic [3:0][51:0] in_corner,
  input  logic [22:0]      view_width,
  input  logic [22:0]      view_height,
  output logic             res_valid,
  output sq_item_t         res_item,
  output logic [47:0]      res_n
);

  val_t pwv, phv;
  assign pwv = val_t'({1'b0, view_width});
  assign phv = val_t'({1'b0, view_height});

  // Stage A: products
  logic             a_valid_r;
  logic signed [47:0] a_prod_r [6];
  val_t [5:0]       a_v_r;
  logic [11:0]      a_fl_r;
  logic             a_full_r;
  logic [3:0][51:0] a_corner_r;

  // Stage B: scaled values
  logic             b_valid_r;
  val_t [5:0]       b_v_r;
  logic [5:0]       b_d_r;
  logic             b_full_r;
  logic [3:0][51:0] b_corner_r;
  val_t [5:0]       b_v_nxt;

  // Stage C: geometry
  logic             c_valid_r;
  val_t             c_x_r, c_y_r, c_w_r, c_h_r;
  logic             c_full_r;
  logic [3:0][51:0] c_corner_r;
  val_t             c_x_nxt, c_y_nxt, c_w_nxt, c_h_nxt;

  // Stage D: box, halves, squares
  logic             d_valid_r;
  geo_t             d_geo_r;
  logic [46:0]      d_wsq_r, d_hsq_r;
  logic             d_full_r;
  logic [3:0][51:0] d_corner_r;
  logic signed [47:0] wsq, hsq;

  // Stage E: half the sum of squares
  logic             e_valid_r;
  sq_item_t         e_item_r;
  logic [47:0]      e_n_r;
  logic [47:0]      sum_sq;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (!a_fl_r[i]) b_v_nxt[i] = '0;
      else if (a_fl_r[i + 6]) b_v_nxt[i] = mulq(a_prod_r[i], FRAC_BITS);
      else b_v_nxt[i] = a_v_r[i];
    end
  end

  always_comb begin
    if (b_d_r[0]) c_x_nxt = b_v_r[0];
    else if (b_d_r[2] && b_d_r[4]) c_x_nxt = ssub(ssub(pwv, b_v_r[2]), b_v_r[4]);
    else c_x_nxt = '0;
    if (b_d_r[1]) c_y_nxt = b_v_r[1];
    else if (b_d_r[3] && b_d_r[5]) c_y_nxt = ssub(ssub(phv, b_v_r[3]), b_v_r[5]);
    else c_y_nxt = '0;
    // undefined values are already zero, so v0 stands for x when it was not given
    if (b_d_r[2]) c_w_nxt = b_v_r[2];
    else if (b_d_r[4]) c_w_nxt = ssub(ssub(pwv, b_v_r[4]), b_v_r[0]);
    else c_w_nxt = pwv;
    if (b_d_r[3]) c_h_nxt = b_v_r[3];
    else if (b_d_r[5]) c_h_nxt = ssub(ssub(phv, b_v_r[5]), b_v_r[1]);
    else c_h_nxt = phv;
  end

  assign wsq    = c_w_r * c_w_r;
  assign hsq    = c_h_r * c_h_r;
  assign sum_sq = {1'b0, d_wsq_r} + {1'b0, d_hsq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        a_prod_r[i] <= in_val[i] * (((i % 2) == 0) ? pwv : phv);
      end
      a_v_r      <= in_val;
      a_fl_r     <= in_flags;
      a_full_r   <= in_full;
      a_corner_r <= in_corner;

      b_v_r      <= b_v_nxt;
      b_d_r      <= a_fl_r[5:0];
      b_full_r   <= a_full_r;
      b_corner_r <= a_corner_r;

      c_x_r      <= c_x_nxt;
      c_y_r      <= c_y_nxt;
      c_w_r      <= c_w_nxt;
      c_h_r      <= c_h_nxt;
      c_full_r   <= b_full_r;
      c_corner_r <= b_corner_r;

      d_geo_r.x        <= c_x_r;
      d_geo_r.y        <= c_y_r;
      d_geo_r.xw       <= sadd(c_x_r, c_w_r);
      d_geo_r.yh       <= sadd(c_y_r, c_h_r);
      d_geo_r.hw       <= c_w_r >>> 1;
      d_geo_r.hh       <= c_h_r >>> 1;
      d_geo_r.drawable <= (c_w_r != 0) && (c_h_r != 0);
      d_wsq_r          <= wsq[46:0];
      d_hsq_r          <= hsq[46:0];
      d_full_r         <= c_full_r;
      d_corner_r       <= c_corner_r;

      e_item_r.geo    <= d_geo_r;
      e_item_r.full   <= d_full_r;
      e_item_r.corner <= d_corner_r;
      e_n_r           <= sum_sq >> 1;
    end
  end

  assign res_valid = e_valid_r;
  assign res_item  = e_item_r;
  assign res_n     = e_n_r;

endmodule

[design/rrp_isqrt.sv]
// Pipelined integer square root, two result bits per stage, with the item carried alongside.
// Depends on rrp_pkg.
module rrp_isqrt import rrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  sq_item_t    in_item,
  input  logic [47:0] in_n,
  output logic        sq_valid,
  output sq_item_t    sq_item,
  output logic [23:0] sq_root
);

  logic        valid_r [SQRT_STAGES];
  sq_item_t    item_r  [SQRT_STAGES];
  logic [47:0] n_r     [SQRT_STAGES];
  logic [27:0] rem_r   [SQRT_STAGES];
  logic [23:0] root_r  [SQRT_STAGES];

  logic [47:0] n_nxt    [SQRT_STAGES];
  logic [27:0] rem_nxt  [SQRT_STAGES];
  logic [23:0] root_nxt [SQRT_STAGES];

  always_comb begin
    logic [47:0] n;
    logic [27:0] rem;
    logic [23:0] root;
    logic [27:0] trial;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        n    = in_n;
        rem  = '0;
        root = '0;
      end else begin
        n    = n_r[s - 1];
        rem  = rem_r[s - 1];
        root = root_r[s - 1];
      end
      for (int k = 0; k < 2; k++) begin
        rem   = {rem[25:0], n[47:46]};
        n     = {n[45:0], 2'b00};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[22:0], 1'b1};
        end else begin
          root = {root[22:0], 1'b0};
        end
      end
      n_nxt[s]    = n;
      rem_nxt[s]  = rem;
      root_nxt[s] = root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SQRT_STAGES; s++) valid_r[s] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int s = 1; s < SQRT_STAGES; s++) valid_r[s] <= valid_r[s - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int s = 1; s < SQRT_STAGES; s++) item_r[s] <= item_r[s - 1];
      for (int s = 0; s < SQRT_STAGES; s++) begin
        n_r[s]    <= n_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign sq_valid = valid_r[SQRT_STAGES - 1];
  assign sq_item  = item_r[SQRT_STAGES - 1];
  assign sq_root  = root_r[SQRT_STAGES - 1];

endmodule

[design/rrp_corner.sv]
// Corner stages: scale radii by the diagonal, apply the identical or per-corner rules
// and choose square or rounded path. Depends on rrp_pkg.
module rrp_corner import rrp_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  sq_item_t    in_item,
  input  logic [23:0] in_root,
  output logic        path_valid,
  output path_t       path
);

  val_t diag;
  assign diag = (in_root > 24'(VMAX)) ? VMAX : val_t'(in_root);

  // Stage F: radius products
  logic               f_valid_r;
  sq_item_t           f_item_r;
  logic signed [47:0] f_px_r [4];
  logic signed [47:0] f_py_r [4];

  // Stage G: resolved radii
  logic  g_valid_r;
  path_t g_path_r;
  path_t path_nxt;

  always_comb begin
    val_t ax [4];
    val_t by [4];
    val_t a, b;
    logic [51:0] c;
    for (int i = 0; i < 4; i++) begin
      c     = f_item_r.corner[i];
      ax[i] = c[50] ? mulq(f_px_r[i], FRAC_BITS) : val_t'(c[23:0]);
      by[i] = c[51] ? mulq(f_py_r[i], FRAC_BITS) : val_t'(c[47:24]);
    end
    path_nxt.geo = f_item_r.geo;
    c = f_item_r.corner[0];
    // identical corners: a missing radius copies the other, then clamp to [0, half side]
    a = c[48] ? ax[0] : by[0];
    b = c[49] ? by[0] : a;
    a = (a < 0) ? '0 : ((f_item_r.geo.hw < a) ? f_item_r.geo.hw : a);
    b = (b < 0) ? '0 : ((f_item_r.geo.hh < b) ? f_item_r.geo.hh : b);
    path_nxt.rounded = f_item_r.full || ((c[49:48] != 2'b00) && (a != 0) && (b != 0));
    for (int i = 0; i < 4; i++) begin
      if (f_item_r.full) begin
        c = f_item_r.corner[i];
        path_nxt.rx[i] = c[48] ? ((ax[i] > f_item_r.geo.hw) ? f_item_r.geo.hw : ax[i]) :
                                 ((f_item_r.geo.hw < 0) ? f_item_r.geo.hw : '0);
        path_nxt.ry[i] = c[49] ? ((by[i] > f_item_r.geo.hh) ? f_item_r.geo.hh : by[i]) :
                                 ((f_item_r.geo.hh < 0) ? f_item_r.geo.hh : '0);
      end else begin
        path_nxt.rx[i] = a;
        path_nxt.ry[i] = b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_valid;
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_item_r <= in_item;
      for (int i = 0; i < 4; i++) begin
        f_px_r[i] <= val_t'(in_item.corner[i][23:0]) * diag;
        f_py_r[i] <= val_t'(in_item.corner[i][47:24]) * diag;
      end
      g_path_r <= path_nxt;
    end
  end

  assign path_valid = g_valid_r;
  assign path       = g_path_r;

endmodule

[design/rrp_emit.sv]
// Path sequencer: steps through the commands of one resolved rectangle into the
// output register. Depends on rrp_pkg.
module rrp_emit import rrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  path_t       in_path,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output val_t        out_point_x,
  output val_t        out_point_y,
  output logic [22:0] out_arc_radius_x,
  output logic [22:0] out_arc_radius_y,
  output val_t        out_bound_left,
  output val_t        out_bound_top,
  output val_t        out_bound_right,
  output val_t        out_bound_bottom,
  output logic        out_drawable,
  output logic        out_last
);

  path_t       hold_r;
  logic        hold_valid_r;
  logic [3:0]  cnt_r;
  logic        out_valid_r;
  cmd_t        cmd_r;
  val_t        px_r, py_r, bl_r, bt_r, br_r, bb_r;
  logic [22:0] rx_r, ry_r;
  logic        draw_r, last_r;

  logic        out_free, fire, is_last;
  cmd_t        cmd_nxt;
  val_t        px_nxt, py_nxt, rxs, rys;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = hold_valid_r && out_free;
  assign is_last  = hold_r.rounded ? (cnt_r == 4'd9) : (cnt_r == 4'd4);
  assign take     = !hold_valid_r || (fire && is_last);

  always_comb begin
    geo_t g;
    g       = hold_r.geo;
    cmd_nxt = CMD_LINE;
    px_nxt  = g.x;
    py_nxt  = g.y;
    rxs     = '0;
    rys     = '0;
    if (hold_r.rounded) begin
      case (cnt_r)
        4'd0: begin cmd_nxt = CMD_MOVE; px_nxt = sadd(g.x, hold_r.rx[0]); end
        4'd1: px_nxt = ssub(g.xw, hold_r.rx[1]);
        4'd2: begin
          cmd_nxt = CMD_ARC; px_nxt = g.xw; py_nxt = sadd(g.y, hold_r.ry[1]);
          rxs = hold_r.rx[1]; rys = hold_r.ry[1];
        end
        4'd3: begin px_nxt = g.xw; py_nxt = ssub(g.yh, hold_r.ry[2]); end
        4'd4: begin
          cmd_nxt = CMD_ARC; px_nxt = ssub(g.xw, hold_r.rx[2]); py_nxt = g.yh;
          rxs = hold_r.rx[2]; rys = hold_r.ry[2];
        end
        4'd5: begin px_nxt = sadd(g.x, hold_r.rx[3]); py_nxt = g.yh; end
        4'd6: begin
          cmd_nxt = CMD_ARC; py_nxt = ssub(g.yh, hold_r.ry[3]);
          rxs = hold_r.rx[3]; rys = hold_r.ry[3];
        end
        4'd7: py_nxt = sadd(g.y, hold_r.ry[0]);
        4'd8: begin
          cmd_nxt = CMD_ARC; px_nxt = sadd(g.x, hold_r.rx[0]);
          rxs = hold_r.rx[0]; rys = hold_r.ry[0];
        end
        default: begin cmd_nxt = CMD_CLOSE; px_nxt = sadd(g.x, hold_r.rx[0]); end
      endcase
    end else begin
      case (cnt_r)
        4'd0: cmd_nxt = CMD_MOVE;
        4'd1: px_nxt = g.xw;
        4'd2: begin px_nxt = g.xw; py_nxt = g.yh; end
        4'd3: py_nxt = g.yh;
        default: cmd_nxt = CMD_CLOSE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        hold_valid_r <= in_valid;
        cnt_r        <= '0;
      end else if (fire) begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) hold_r <= in_path;
    if (fire) begin
      cmd_r  <= cmd_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      rx_r   <= (cmd_nxt == CMD_ARC) ? radius_mag(rxs) : '0;
      ry_r   <= (cmd_nxt == CMD_ARC) ? radius_mag(rys) : '0;
      bl_r   <= is_last ? hold_r.geo.x : '0;
      bt_r   <= is_last ? hold_r.geo.y : '0;
      br_r   <= is_last ? hold_r.geo.xw : '0;
      bb_r   <= is_last ? hold_r.geo.yh : '0;
      draw_r <= is_last && hold_r.geo.drawable;
      last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = cmd_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_arc_radius_x = rx_r;
  assign out_arc_radius_y = ry_r;
  assign out_bound_left   = bl_r;
  assign out_bound_top    = bt_r;
  assign out_bound_right  = br_r;
  assign out_bound_bottom = bb_r;
  assign out_drawable     = draw_r;
  assign out_last         = last_r;

endmodule

[design/rounded_rect_path_generator_top.sv]
// Rounded rectangle path generator, top level. Uses rrp_pkg, rrp_resolve, rrp_isqrt,
// rrp_corner and rrp_emit.
// The pipeline has 19 stages, 12 of them the two-bit-per-stage square root, followed by the
// sequencer hold register and the output register. The sequencer issues one command per cycle
// while the output is not stalled, ten for a rounded rectangle and five for a square one, and
// loads the next rectangle as it issues the last command of the current one.
// Reset clears all valid bits and the viewport size registers.
module rounded_rect_path_generator_top import rrp_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] in_rect_x,
  input  logic signed [23:0] in_rect_y,
  input  logic signed [23:0] in_rect_width,
  input  logic signed [23:0] in_rect_height,
  input  logic signed [23:0] in_right_offset,
  input  logic signed [23:0] in_bottom_offset,
  input  logic [11:0] in_presence_flags,
  input  logic        in_full_control,
  input  logic [51:0] in_corner_top_left,
  input  logic [51:0] in_corner_top_right,
  input  logic [51:0] in_corner_bottom_right,
  input  logic [51:0] in_corner_bottom_left,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic signed [23:0] out_point_x,
  output logic signed [23:0] out_point_y,
  output logic [22:0] out_arc_radius_x,
  output logic [22:0] out_arc_radius_y,
  output logic signed [23:0] out_bound_left,
  output logic signed [23:0] out_bound_top,
  output logic signed [23:0] out_bound_right,
  output logic signed [23:0] out_bound_bottom,
  output logic        out_drawable,
  output logic        out_last
);

  logic [22:0] view_width_r, view_height_r;

  logic             en;
  logic             rs_valid, sq_valid, pa_valid, take;
  sq_item_t         rs_item, sq_item;
  logic [47:0]      rs_n;
  logic [23:0]      sq_root;
  path_t            pa_path;
  val_t [5:0]       in_val;
  logic [3:0][51:0] in_corner;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {9'd0, view_height_r} : {9'd0, view_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r  <= '0;
      view_height_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) view_height_r <= pwdata[22:0];
      else view_width_r <= pwdata[22:0];
    end
  end

  assign in_val    = {in_bottom_offset, in_right_offset, in_rect_height,
                      in_rect_width, in_rect_y, in_rect_x};
  assign in_corner = {in_corner_bottom_left, in_corner_bottom_right,
                      in_corner_top_right, in_corner_top_left};

  // advance the whole pipeline unless its last stage holds an item the sequencer refuses
  assign en       = !pa_valid || take;
  assign in_stall = !en;

  rrp_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk, .rst_n, .en,
    .in_valid, .in_val,
    .in_flags(in_presence_flags),
    .in_full(in_full_control),
    .in_corner,
    .view_width(view_width_r),
    .view_height(view_height_r),
    .res_valid(rs_valid), .res_item(rs_item), .res_n(rs_n)
  );

  rrp_isqrt u_isqrt (
    .clk, .rst_n, .en,
    .in_valid(rs_valid), .in_item(rs_item), .in_n(rs_n),
    .sq_valid, .sq_item, .sq_root
  );

  rrp_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
    .clk, .rst_n, .en,
    .in_valid(sq_valid), .in_item(sq_item), .in_root(sq_root),
    .path_valid(pa_valid), .path(pa_path)
  );

  rrp_emit u_emit (
    .clk, .rst_n,
    .in_valid(pa_valid), .in_path(pa_path), .take,
    .out_valid, .out_stall, .out_command,
    .out_point_x, .out_point_y,
    .out_arc_radius_x, .out_arc_radius_y,
    .out_bound_left, .out_bound_top, .out_bound_right, .out_bound_bottom,
    .out_drawable, .out_last
  );

`ifndef SYNTH
  a_last_is_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_command == CMD_CLOSE)))
    else $error("last flag disagrees with close command");

  a_radius_only_on_arc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_command != CMD_ARC)) |->
      (out_arc_radius_x == 0 && out_arc_radius_y == 0))
    else $error("radius on non-arc command");

  a_bounds_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (!out_drawable && out_bound_left == 0 &&
                                  out_bound_right == 0 && out_bound_top == 0 &&
                                  out_bound_bottom == 0))
    else $error("bounding box outside last command");
`endif

endmodule

[tb/tb_rounded_rect_path_generator_top.sv]
// Self-checking testbench of rounded_rect_path_generator_top: directed table, then random rectangles.
// Depends on rrp_pkg and the design files; the path predictor is held here.
`timescale 1ns / 1ps
module tb_rounded_rect_path_generator_top;
  import rrp_pkg::*;

  localparam int  FRAC      = 8;
  localparam longint SMAX   = 8388607;
  localparam longint SMIN   = -8388608;
  localparam int  LIMIT     = 300000;
  localparam logic [2:0] ADDR_PARENT_W = 3'd0;
  localparam logic [2:0] ADDR_PARENT_H = 3'd4;

  typedef struct {
    logic signed [23:0] x, y, w, h, ro, bo;
    logic [11:0]        flags;
    logic               full;
    logic [3:0][51:0]   corner;
  } rect_t;

  typedef struct {
    rect_t  r;
    bit     typed;
    longint mx, my;
  } row_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [23:0] px, py;
    logic [22:0]        rx, ry;
    logic signed [23:0] bl, bt, br, bb;
    logic               drw, last;
  } path_cmd_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [23:0] in_rect_x, in_rect_y, in_rect_width, in_rect_height;
  logic signed [23:0] in_right_offset, in_bottom_offset;
  logic [11:0] in_presence_flags;
  logic in_full_control;
  logic [51:0] in_corner_top_left, in_corner_top_right;
  logic [51:0] in_corner_bottom_right, in_corner_bottom_left;
  logic [1:0] out_command;
  logic signed [23:0] out_point_x, out_point_y;
  logic [22:0] out_arc_radius_x, out_arc_radius_y;
  logic signed [23:0] out_bound_left, out_bound_top, out_bound_right, out_bound_bottom;
  logic out_drawable, out_last;

  rounded_rect_path_generator_top uut (.*);

  path_cmd_t path_q[$];
  row_t      dir_tab[$];
  longint    pw, ph;
  int        errors, n_items, n_cmds, cyc;
  bit        quiet, hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint q_scale(input longint a, input longint b);
    return clip((a * b + (longint'(1) << (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic longint int_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [22:0] mag23(input longint r);
    if (r < 0) r = -r;
    if (r > SMAX) r = SMAX;
    return r[22:0];
  endfunction

  task automatic add_cmd(input cmd_t c, input longint px, input longint py,
                         input longint rx, input longint ry);
    path_cmd_t p;
    p = '0;
    p.cmd = c;
    p.px = px[23:0];
    p.py = py[23:0];
    if (c == CMD_ARC) begin
      p.rx = mag23(rx);
      p.ry = mag23(ry);
    end
    path_q.push_back(p);
  endtask

  // Resolve one rectangle into its expected path commands
  task automatic predict_path(input rect_t r);
    longint v[6];
    bit d[6];
    longint x, y, w, h, xw, yh, hw, hh, diag, a, b, p;
    longint rx[4], ry[4];
    logic [51:0] c;
    bit rnd;
    path_cmd_t fin;
    v[0] = r.x; v[1] = r.y; v[2] = r.w; v[3] = r.h; v[4] = r.ro; v[5] = r.bo;
    for (int i = 0; i < 6; i++) begin
      p = (i % 2 == 0) ? pw : ph;
      d[i] = r.flags[i];
      if (r.flags[i + 6]) v[i] = q_scale(v[i], p);
      if (!d[i]) v[i] = 0;
    end
    if (d[0]) x = v[0];
    else if (d[2] && d[4]) x = clip(clip(pw - v[2]) - v[4]);
    else x = 0;
    if (d[1]) y = v[1];
    else if (d[3] && d[5]) y = clip(clip(ph - v[3]) - v[5]);
    else y = 0;
    if (d[2]) w = v[2];
    else if (d[4]) begin
      if (!d[0]) x = 0;
      w = clip(clip(pw - v[4]) - x);
    end else w = pw;
    if (d[3]) h = v[3];
    else if (d[5]) begin
      if (!d[1]) y = 0;
      h = clip(clip(ph - v[5]) - y);
    end else h = ph;
    xw = clip(x + w);
    yh = clip(y + h);
    hw = w >>> 1;
    hh = h >>> 1;
    diag = clip(int_root(longint'((longint'(w * w) + longint'(h * h)) / 2)));
    rnd = 1'b0;
    if (r.full) begin
      for (int i = 0; i < 4; i++) begin
        c = r.corner[i];
        a = $signed(c[23:0]);
        b = $signed(c[47:24]);
        if (c[50]) a = q_scale(a, diag);
        if (c[51]) b = q_scale(b, diag);
        if (!c[48]) a = 0;
        if (!c[49]) b = 0;
        if (a > hw) a = hw;
        if (b > hh) b = hh;
        rx[i] = a;
        ry[i] = b;
      end
      rnd = 1'b1;
    end else if (r.corner[0][49:48] != 2'b00) begin
      c = r.corner[0];
      a = $signed(c[23:0]);
      b = $signed(c[47:24]);
      if (c[50]) a = q_scale(a, diag);
      if (c[51]) b = q_scale(b, diag);
      if (!c[48]) a = b;
      if (!c[49]) b = a;
      a = (a < 0) ? 0 : ((hw < a) ? hw : a);
      b = (b < 0) ? 0 : ((hh < b) ? hh : b);
      if (a != 0 && b != 0) begin
        for (int i = 0; i < 4; i++) begin
          rx[i] = a;
          ry[i] = b;
        end
        rnd = 1'b1;
      end
    end
    if (rnd) begin
      add_cmd(CMD_MOVE, clip(x + rx[0]), y, 0, 0);
      add_cmd(CMD_LINE, clip(xw - rx[1]), y, 0, 0);
      add_cmd(CMD_ARC, xw, clip(y + ry[1]), rx[1], ry[1]);
      add_cmd(CMD_LINE, xw, clip(yh - ry[2]), 0, 0);
      add_cmd(CMD_ARC, clip(xw - rx[2]), yh, rx[2], ry[2]);
      add_cmd(CMD_LINE, clip(x + rx[3]), yh, 0, 0);
      add_cmd(CMD_ARC, x, clip(yh - ry[3]), rx[3], ry[3]);
      add_cmd(CMD_LINE, x, clip(y + ry[0]), 0, 0);
      add_cmd(CMD_ARC, clip(x + rx[0]), y, rx[0], ry[0]);
      add_cmd(CMD_CLOSE, clip(x + rx[0]), y, 0, 0);
    end else begin
      add_cmd(CMD_MOVE, x, y, 0, 0);
      add_cmd(CMD_LINE, xw, y, 0, 0);
      add_cmd(CMD_LINE, xw, yh, 0, 0);
      add_cmd(CMD_LINE, x, yh, 0, 0);
      add_cmd(CMD_CLOSE, x, y, 0, 0);
    end
    // bounding box and drawable ride on the closing command
    fin = path_q.pop_back();
    fin.bl = x[23:0];
    fin.bt = y[23:0];
    fin.br = xw[23:0];
    fin.bb = yh[23:0];
    fin.drw = (w != 0 && h != 0);
    fin.last = 1'b1;
    path_q.push_back(fin);
  endtask

  function automatic rect_t mk(input longint x, input longint y, input longint w,
                               input longint h, input longint ro, input longint bo,
                               input logic [11:0] fl, input logic full,
                               input logic [51:0] c0, input logic [51:0] c1,
                               input logic [51:0] c2, input logic [51:0] c3);
    rect_t r;
    r.x = x[23:0]; r.y = y[23:0]; r.w = w[23:0]; r.h = h[23:0];
    r.ro = ro[23:0]; r.bo = bo[23:0];
    r.flags = fl;
    r.full = full;
    r.corner = {c3, c2, c1, c0};
    return r;
  endfunction

  function automatic logic [51:0] crn(input bit dx, input bit dy, input bit sx, input bit sy,
                                      input longint rx, input longint ry);
    return {sy, sx, dy, dx, ry[23:0], rx[23:0]};
  endfunction

  function automatic longint rand_val();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2, 3: return longint'($signed(24'($urandom)));
      default: return longint'($urandom_range(0, 51200)) - 25600;
    endcase
  endfunction

  function automatic logic [51:0] rand_corner();
    longint a, b;
    a = ($urandom_range(0, 5) == 0) ? rand_val() : longint'($urandom_range(0, 6400));
    b = ($urandom_range(0, 5) == 0) ? rand_val() : longint'($urandom_range(0, 6400));
    if ($urandom_range(0, 7) == 0) return 52'($urandom) | (52'($urandom) << 32);
    return crn($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, a, b);
  endfunction

  function automatic rect_t rand_rect();
    logic [11:0] fl;
    fl = 12'($urandom);
    // mostly plain geometry with x, y, width and height given
    if ($urandom_range(0, 2) != 0) fl[3:0] = 4'hF;
    if ($urandom_range(0, 1) != 0) fl[11:6] = '0;
    return mk(rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
              fl, 1'($urandom_range(0, 1)), rand_corner(), rand_corner(), rand_corner(),
              rand_corner());
  endfunction

  task automatic cfg_write(input logic [2:0] addr, input longint val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_PARENT_W) pw = val & 64'h7FFFFF;
    else ph = val & 64'h7FFFFF;
  endtask

  // Reprogram the parent size once the pipeline has drained
  task automatic set_parent(input longint w, input longint h);
    wait (path_q.size() == 0);
    repeat (30) @(posedge clk);
    cfg_write(ADDR_PARENT_W, w);
    cfg_write(ADDR_PARENT_H, h);
  endtask

  // Offer one rectangle; called at a rising edge, returns at its acceptance edge
  task automatic send_rect(input rect_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rect_x <= r.x;
    in_rect_y <= r.y;
    in_rect_width <= r.w;
    in_rect_height <= r.h;
    in_right_offset <= r.ro;
    in_bottom_offset <= r.bo;
    in_presence_flags <= r.flags;
    in_full_control <= r.full;
    in_corner_top_left <= r.corner[0];
    in_corner_top_right <= r.corner[1];
    in_corner_bottom_right <= r.corner[2];
    in_corner_bottom_left <= r.corner[3];
    do @(posedge clk); while (in_stall);
    predict_path(r);
    n_items++;
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  // Result side: check each transaction, stall in random bursts or on a long hold
  initial begin
    int burst, hold;
    path_cmd_t e;
    burst = 0;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        n_cmds++;
        if (path_q.size() == 0) begin
          $error("unexpected path command %0d", out_command);
          errors++;
        end else begin
          e = path_q.pop_front();
          check_field("command", e.cmd, out_command);
          check_field("point_x", e.px, out_point_x);
          check_field("point_y", e.py, out_point_y);
          check_field("arc_radius_x", e.rx, out_arc_radius_x);
          check_field("arc_radius_y", e.ry, out_arc_radius_y);
          check_field("bound_left", e.bl, out_bound_left);
          check_field("bound_top", e.bt, out_bound_top);
          check_field("bound_right", e.br, out_bound_right);
          check_field("bound_bottom", e.bb, out_bound_bottom);
          check_field("drawable", e.drw, out_drawable);
          check_field("last", e.last, out_last);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > LIMIT) begin
        $display("tb_rounded_rect_path_generator_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    longint cw[4], chh[4];
    errors = 0; n_items = 0; n_cmds = 0; pw = 0; ph = 0;
    quiet = 1'b0; hold_req = 1'b0;
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid <= 1'b0;
    in_rect_x <= '0; in_rect_y <= '0; in_rect_width <= '0; in_rect_height <= '0;
    in_right_offset <= '0; in_bottom_offset <= '0; in_presence_flags <= '0;
    in_full_control <= 1'b0;
    in_corner_top_left <= '0; in_corner_top_right <= '0;
    in_corner_bottom_right <= '0; in_corner_bottom_left <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Parent size at reset (zero): with nothing given, the first row is a zero-sized square at the origin
    dir_tab.push_back('{mk(0, 0, 0, 0, 0, 0, 12'h000, 0, 0, 0, 0, 0), 1, 0, 0});
    dir_tab.push_back('{mk(SMAX, SMIN, 0, 0, 0, 0, 12'h003, 0, 0, 0, 0, 0), 1, SMAX, SMIN});
    dir_tab.push_back('{mk(SMIN, SMAX, SMAX, SMAX, 0, 0, 12'h00F, 0, 0, 0, 0, 0),
                        1, SMIN, SMAX});
    dir_tab.push_back('{mk(SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, 12'hFFF, 1,
                           crn(1, 1, 1, 1, SMAX, SMIN), crn(1, 1, 0, 0, SMIN, SMIN),
                           crn(1, 1, 0, 0, SMAX, SMAX), crn(0, 0, 1, 1, SMIN, SMAX)),
                        0, 0, 0});
    foreach (dir_tab[i]) begin
      send_rect(dir_tab[i].r);
      if (dir_tab[i].typed && (path_q[$ - 4].px != dir_tab[i].mx[23:0] ||
                               path_q[$ - 4].py != dir_tab[i].my[23:0])) begin
        $error("start point of row %0d: expected %0h,%0h", i, dir_tab[i].mx, dir_tab[i].my);
        errors++;
      end
    end
    in_valid <= 1'b0;

    // Parent 100.0 by 50.0: offsets, scaling and every corner mode
    set_parent(25600, 12800);
    dir_tab.delete();
    dir_tab.push_back('{mk(128, 0, 0, 0, 0, 0, 12'h041, 0, 0, 0, 0, 0), 1, 12800, 0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 2560, 2560, 12'h030, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 5120, 0, 2560, 0, 12'h014, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 0, 1280, 0, 640, 12'h028, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 0, 128, 0, 64, 12'hA2A, 0, 0, 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(256, 512, 12800, 6400, 0, 0, 12'h00F, 0,
                           crn(1, 0, 0, 0, 2560, 0), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(256, 512, 12800, 6400, 0, 0, 12'h00F, 0,
                           crn(0, 1, 0, 0, 99, 1280), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 12800, 6400, 0, 0, 12'h00F, 0,
                           crn(1, 1, 0, 0, SMAX, SMAX), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 12800, 6400, 0, 0, 12'h00F, 0,
                           crn(1, 1, 0, 0, -256, 1280), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 12800, 6400, 0, 0, 12'h00F, 0,
                           crn(1, 1, 1, 1, 13, 26), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(-2560, -2560, 12800, 6400, 0, 0, 12'h00F, 1,
                           crn(1, 1, 0, 0, 640, 320), crn(1, 0, 0, 0, -640, 77),
                           crn(0, 1, 1, 0, 5, 6400), crn(1, 1, 1, 1, 64, 32)), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 12800, 6400, 0, 0, 12'h00F, 1,
                           crn(1, 1, 0, 0, SMIN, SMIN), crn(1, 1, 0, 0, SMAX, SMAX),
                           crn(1, 1, 1, 1, SMIN, SMAX), crn(0, 0, 0, 0, 1, 1)), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, 0, 6400, 0, 0, 12'h00F, 0,
                           crn(1, 1, 0, 0, 256, 256), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(2560, 2560, -5120, -5120, 0, 0, 12'h00F, 1,
                           crn(1, 1, 0, 0, -512, -512), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(0, 0, SMAX, SMAX, 0, 0, 12'h0CC, 0,
                           crn(1, 1, 1, 1, 128, 128), 0, 0, 0), 0, 0, 0});
    dir_tab.push_back('{mk(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 12'hFC0, 0, 0, 0, 0, 0),
                        0, 0, 0});
    foreach (dir_tab[i]) send_rect(dir_tab[i].r);
    in_valid <= 1'b0;

    // Random rectangles under several parent sizes, extremes included
    cw[0] = 0;    chh[0] = 0;
    cw[1] = SMAX; chh[1] = SMAX;
    cw[2] = 51200; chh[2] = 25600;
    cw[3] = $urandom_range(0, 8388607); chh[3] = $urandom_range(0, 8388607);
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      set_parent(cw[ph_i], chh[ph_i]);
      quiet = (ph_i == 3);
      for (int k = 0; k < 35; k++) begin
        if (ph_i == 1 && k == 5) hold_req = 1'b1;
        if (ph_i == 2 && k == 20) begin
          // hold off until every queued command has come back
          in_valid <= 1'b0;
          wait (path_q.size() == 0);
          @(posedge clk);
        end
        send_rect(rand_rect());
      end
      in_valid <= 1'b0;
    end

    wait (path_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d rectangles over six parent sizes, checked %0d path commands",
             n_items, n_cmds);
    $display("covering square, identical and per-corner paths with long output back-pressure");
    if (errors == 0 && path_q.size() == 0) begin
      $display("tb_rounded_rect_path_generator_top OK");
    end else begin
      $display("tb_rounded_rect_path_generator_top NOT OK");
    end
    $finish;
  end

endmodule
